// File: hw/rtl/tbms_pkg.sv
// ----------------------------------------------------------------------------
// tbms_pkg
// Types, codes and helpers shared by the track bookkeeping and motion status
// block: request and response beats, the stored track entry, and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package tbms_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_MAX_COAST      = 3'd0,
      REG_STOP_ONCOMING  = 3'd1,
      REG_STOP_FOLLOWING = 3'd2,
      REG_DRIVE_FORWARD  = 3'd3,
      REG_DRIVE_BACKWARD = 3'd4,
      REG_CHANGE_COUNT   = 3'd5
   } reg_index_type;

   localparam logic [1:0] ST_NEW     = 2'd0;
   localparam logic [1:0] ST_UPDATED = 2'd1;
   localparam logic [1:0] ST_COASTED = 2'd2;
   localparam logic [1:0] ST_DELETED = 2'd3;

   localparam logic [2:0] MP_STATIONARY       = 3'd0;
   localparam logic [2:0] MP_ONCOMING         = 3'd1;
   localparam logic [2:0] MP_RECEDING         = 3'd2;
   localparam logic [2:0] MP_ONCOMING_STOPPED = 3'd3;
   localparam logic [2:0] MP_DRIVING_STOPPED  = 3'd4;

   typedef struct packed {
      logic [5:0]         track_id;
      logic               fresh;
      logic               has_vision;
      logic               has_radar;
      logic               vision_measured;
      logic               radar_updated;
      logic signed [15:0] long_velocity;
   } req_type;

   typedef struct packed {
      logic [5:0]  track_id_res;
      logic [1:0]  track_status;
      logic [2:0]  motion_pattern;
      logic        moveable;
      logic [15:0] scans_since_update;
      logic        never_radar_vision;
      logic [15:0] scans_since_radar_vision;
      logic [15:0] scans_in_fusion;
      logic [15:0] age_scans;
   } rsp_type;

   typedef struct packed {
      logic [1:0] spare;
      logic       hist_onc;
      logic       moveable;
      logic       onc;
      logic       moving;
      logic [7:0] cnt;
   } motion_type;

   typedef struct packed {
      logic [15:0] age;
      logic [15:0] coast;
      logic        rv_never;
      logic [15:0] rv_cnt;
      logic [15:0] fus;
      motion_type  mot;
   } entry_type;

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      sat_inc16 = (v == 16'hFFFF) ? 16'hFFFF : v + 16'd1;
   endfunction

   function automatic logic [7:0] sat_inc8(input logic [7:0] v);
      sat_inc8 = (v == 8'hFF) ? 8'hFF : v + 8'd1;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tbms_ram.sv
// ----------------------------------------------------------------------------
// tbms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tbms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/track_bookkeeping_motion_status.sv
// ----------------------------------------------------------------------------
// track_bookkeeping_motion_status
// Per-track table of coast, radar-vision and fusion timers with a hysteresis
// motion classifier; one read-modify-write of one track entry per beat.
// ----------------------------------------------------------------------------
// Pipeline: the taken beat is registered in s1, its result in rsp_data_ff.
// Throughput: one beat per cycle; busy never rises, the entry RAM read is
//   forwarded from the write of the previous beat when both hit one track.
// Reset: synchronous; clears pipeline valids and loads register defaults.
//   The track RAM is not cleared; an entry holds garbage until opened fresh.
`default_nettype none

module track_bookkeeping_motion_status
   import tbms_pkg::*;
#(
   parameter int NUM_TRACKS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int IDX_W   = $clog2(NUM_TRACKS);
   localparam int ID_SPAN = 64;
   localparam int ENTRY_W = $bits(entry_type);

   logic [IDX_W-1:0] idx_map [ID_SPAN];

   for (genvar g = 0; g < ID_SPAN; g++) begin : g_idx
      localparam int MODV = g % NUM_TRACKS;
      assign idx_map[g] = IDX_W'(MODV);
   end

   logic [15:0]      max_coast_ff;
   logic [15:0]      stop_onc_ff;
   logic [15:0]      stop_fol_ff;
   logic [15:0]      drive_fwd_ff;
   logic [15:0]      drive_bwd_ff;
   logic [7:0]       change_cnt_ff;

   logic             accept;
   logic [IDX_W-1:0] rd_idx;
   logic             s1_valid_ff;
   req_type          s1_req_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic             wr_en_ff;
   logic [IDX_W-1:0] wr_idx_ff;
   entry_type        wr_data_ff;
   logic [ENTRY_W-1:0] ram_rdata;

   entry_type        cur;
   entry_type        nxt;
   rsp_type          res;
   logic             del;
   logic             wr_en_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic             upd;
   logic             both;
   logic [1:0]       status;
   logic [7:0]       need;
   logic [7:0]       cnt_inc;
   logic             q_stop;
   logic             q_drive;
   logic [2:0]       pattern;

   // ---------------------------------------------------------------- csr port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_coast_ff  <= 16'd22;
         stop_onc_ff   <= 16'hFF00;
         stop_fol_ff   <= 16'd256;
         drive_fwd_ff  <= 16'd512;
         drive_bwd_ff  <= 16'hFE00;
         change_cnt_ff <= 8'd5;
      end else if (psel && penable && pwrite && pready) begin
         unique case (paddr[4:2])
            REG_MAX_COAST:      max_coast_ff  <= pwdata[15:0];
            REG_STOP_ONCOMING:  stop_onc_ff   <= pwdata[15:0];
            REG_STOP_FOLLOWING: stop_fol_ff   <= pwdata[15:0];
            REG_DRIVE_FORWARD:  drive_fwd_ff  <= pwdata[15:0];
            REG_DRIVE_BACKWARD: drive_bwd_ff  <= pwdata[15:0];
            REG_CHANGE_COUNT:   change_cnt_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_MAX_COAST:      prdata = {16'd0, max_coast_ff};
         REG_STOP_ONCOMING:  prdata = {{16{stop_onc_ff[15]}}, stop_onc_ff};
         REG_STOP_FOLLOWING: prdata = {{16{stop_fol_ff[15]}}, stop_fol_ff};
         REG_DRIVE_FORWARD:  prdata = {{16{drive_fwd_ff[15]}}, drive_fwd_ff};
         REG_DRIVE_BACKWARD: prdata = {{16{drive_bwd_ff[15]}}, drive_bwd_ff};
         REG_CHANGE_COUNT:   prdata = {24'd0, change_cnt_ff};
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- pipeline
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign rd_idx = idx_map[req_data.track_id];

   tbms_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_TRACKS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en_in),
      .wr_addr (s1_idx_ff),
      .wr_data (nxt),
      .rd_addr (rd_idx),
      .rd_data (ram_rdata)
   );

   always_comb begin
      cur = (wr_en_ff && (wr_idx_ff == s1_idx_ff)) ? wr_data_ff : entry_type'(ram_rdata);
      if (s1_req_ff.fresh) begin
         cur = '0;
      end
      nxt = cur;
      nxt.mot.spare = 2'b00;
      upd  = (s1_req_ff.has_vision && s1_req_ff.vision_measured) ||
             (s1_req_ff.has_radar && s1_req_ff.radar_updated);
      both = s1_req_ff.has_vision && s1_req_ff.has_radar;
      del  = 1'b0;

      if (cur.age != 16'd0) begin
         if (upd) begin
            status    = ST_UPDATED;
            nxt.coast = 16'd0;
         end else begin
            status    = ST_COASTED;
            nxt.coast = sat_inc16(cur.coast);
         end
         del = nxt.coast > max_coast_ff;
         if (both) begin
            nxt.rv_never = 1'b0;
            nxt.rv_cnt   = 16'd0;
            nxt.fus      = sat_inc16(cur.fus);
         end else begin
            nxt.fus = 16'd0;
            if (!cur.rv_never) begin
               nxt.rv_cnt = sat_inc16(cur.rv_cnt);
            end
         end
      end else begin
         status       = ST_NEW;
         nxt.coast    = 16'd0;
         nxt.fus      = 16'd0;
         nxt.rv_never = !both;
         nxt.rv_cnt   = 16'd0;
      end
      nxt.age = sat_inc16(cur.age);

      need    = (change_cnt_ff == 8'd0) ? 8'd1 : change_cnt_ff;
      cnt_inc = sat_inc8(cur.mot.cnt);
      q_stop  = cur.mot.onc ? (s1_req_ff.long_velocity > $signed(stop_onc_ff))
                            : (s1_req_ff.long_velocity < $signed(stop_fol_ff));
      q_drive = (s1_req_ff.long_velocity > $signed(drive_fwd_ff)) ||
                (s1_req_ff.long_velocity < $signed(drive_bwd_ff));

      if (cur.mot.moving) begin
         nxt.mot.cnt = q_stop ? cnt_inc : 8'd0;
         if (q_stop && (cnt_inc >= need)) begin
            nxt.mot.cnt    = 8'd0;
            nxt.mot.moving = 1'b0;
            nxt.mot.onc    = 1'b0;
         end
      end else if (q_drive) begin
         nxt.mot.cnt = cnt_inc;
         if (cnt_inc >= need) begin
            nxt.mot.cnt    = 8'd0;
            nxt.mot.moving = 1'b1;
            nxt.mot.onc    = s1_req_ff.long_velocity[15] &&
                             (!cur.mot.moveable || cur.mot.hist_onc);
         end
      end else begin
         nxt.mot.cnt = 8'd0;
      end
      nxt.mot.moveable = cur.mot.moveable || nxt.mot.moving;

      if (nxt.mot.moving) begin
         pattern          = nxt.mot.onc ? MP_ONCOMING : MP_RECEDING;
         nxt.mot.hist_onc = nxt.mot.onc;
      end else if (nxt.mot.moveable) begin
         pattern = cur.mot.hist_onc ? MP_ONCOMING_STOPPED : MP_DRIVING_STOPPED;
      end else begin
         pattern = MP_STATIONARY;
      end

      res = '0;
      res.track_id_res = s1_req_ff.track_id;
      if (del) begin
         res.track_status = ST_DELETED;
      end else begin
         res.track_status             = status;
         res.motion_pattern           = pattern;
         res.moveable                 = nxt.mot.moveable;
         res.scans_since_update       = nxt.coast;
         res.never_radar_vision       = nxt.rv_never;
         res.scans_since_radar_vision = nxt.rv_never ? 16'd0 : nxt.rv_cnt;
         res.scans_in_fusion          = nxt.fus;
         res.age_scans                = nxt.age;
      end
      wr_en_in = s1_valid_ff && !del;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         wr_en_ff     <= wr_en_in;
         rsp_valid_ff <= s1_valid_ff;
      end
      if (accept) begin
         s1_req_ff <= req_data;
         s1_idx_ff <= rd_idx;
      end
      wr_idx_ff   <= s1_idx_ff;
      wr_data_ff  <= nxt;
      rsp_data_ff <= res;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a request two cycles earlier");

   a_deleted_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.track_status == ST_DELETED) |->
      (rsp_data.age_scans == 16'd0 && !rsp_data.moveable &&
       rsp_data.motion_pattern == MP_STATIONARY))
      else $error("deleted track reports live fields");

   a_never_rv: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.never_radar_vision) |->
      (rsp_data.scans_since_radar_vision == 16'd0 && rsp_data.scans_in_fusion == 16'd0))
      else $error("never radar-vision with running timers");

   a_new_track: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.track_status == ST_NEW) |->
      (rsp_data.age_scans == 16'd1 && rsp_data.scans_since_update == 16'd0))
      else $error("new track with stale age or coast count");

   a_moveable_pattern: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.track_status != ST_DELETED) |->
      ((rsp_data.motion_pattern == MP_STATIONARY) == !rsp_data.moveable))
      else $error("motion pattern disagrees with moveable mark");

endmodule

`default_nettype wire
